### src/acwa_pkg.sv
`timescale 1ns / 1ps

package acwa_pkg;

  localparam int NumWalls = 64;
  localparam int AddrW    = $clog2(NumWalls);
  localparam int WallW    = 6;
  localparam int CompW    = 16;
  localparam int ProdW    = 2 * CompW;
  localparam int TermW    = ProdW + 3;
  localparam int SumW     = 48;

  typedef enum logic [1:0] {
    DirX = 2'd0,
    DirY = 2'd1,
    DirZ = 2'd2,
    DirT = 2'd3
  } dir_e;

  localparam dir_e DirReset = DirT;

  typedef enum logic [1:0] {
    KindAcc   = 2'd0,
    KindRead  = 2'd1,
    KindClear = 2'd2,
    KindNone  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    StIdle,
    StMul,
    StSum,
    StUpd
  } state_e;

  typedef struct packed {
    logic signed [CompW-1:0] re;
    logic signed [CompW-1:0] im;
  } cplx_t;

  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
    logic [SumW-1:0]  data;
  } store_wr_t;

  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
  } store_rd_t;

endpackage

### src/acwa_term.sv
`timescale 1ns / 1ps

module acwa_term (
  input  logic                                clk_i,
  input  logic                                load_i,
  input  acwa_pkg::dir_e                      dir_i,
  input  acwa_pkg::cplx_t                     s0_i,
  input  acwa_pkg::cplx_t                     s1_i,
  input  acwa_pkg::cplx_t                     s2_i,
  input  acwa_pkg::cplx_t                     s3_i,
  output logic signed [acwa_pkg::TermW-1:0]   term_o
);

  localparam int CompW = acwa_pkg::CompW;
  localparam int ProdW = acwa_pkg::ProdW;
  localparam int TermW = acwa_pkg::TermW;

  acwa_pkg::cplx_t a0, a1, b0, b1;
  logic use_re, sub_p2, neg;

  logic signed [CompW-1:0] fx1_q, gx1_q, fy1_q, gy1_q;
  logic signed [CompW-1:0] fx2_q, gx2_q, fy2_q, gy2_q;
  logic use_re_q, sub_p2_q, neg_q;

  logic signed [ProdW-1:0] px1_q, py1_q, px2_q, py2_q;

  logic signed [ProdW:0]   p1, p2;
  logic signed [ProdW+1:0] q;
  logic signed [TermW-1:0] q2;
  logic signed [TermW-1:0] term_d, term_q;

  always_comb begin
    a0     = s0_i;
    a1     = s1_i;
    b0     = s3_i;
    b1     = s2_i;
    use_re = 1'b0;
    sub_p2 = 1'b0;
    neg    = 1'b0;
    unique case (dir_i)
      acwa_pkg::DirX: begin
        b0 = s3_i;
        b1 = s2_i;
      end
      acwa_pkg::DirY: begin
        b0     = s3_i;
        b1     = s2_i;
        use_re = 1'b1;
        sub_p2 = 1'b1;
      end
      acwa_pkg::DirZ: begin
        b0     = s2_i;
        b1     = s3_i;
        sub_p2 = 1'b1;
      end
      acwa_pkg::DirT: begin
        b0     = s2_i;
        b1     = s3_i;
        use_re = 1'b1;
        neg    = 1'b1;
      end
      default: begin
        b0 = s3_i;
        b1 = s2_i;
      end
    endcase
  end

  // Re(b*conj(a)) = br*ar + bi*ai, Im(b*conj(a)) = bi*ar - br*ai
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      fx1_q    <= use_re ? b0.re : b0.im;
      gx1_q    <= a0.re;
      fy1_q    <= use_re ? b0.im : b0.re;
      gy1_q    <= a0.im;
      fx2_q    <= use_re ? b1.re : b1.im;
      gx2_q    <= a1.re;
      fy2_q    <= use_re ? b1.im : b1.re;
      gy2_q    <= a1.im;
      use_re_q <= use_re;
      sub_p2_q <= sub_p2;
      neg_q    <= neg;
    end
  end

  always_ff @(posedge clk_i) begin
    px1_q <= ProdW'(fx1_q) * ProdW'(gx1_q);
    py1_q <= ProdW'(fy1_q) * ProdW'(gy1_q);
    px2_q <= ProdW'(fx2_q) * ProdW'(gx2_q);
    py2_q <= ProdW'(fy2_q) * ProdW'(gy2_q);
  end

  always_comb begin
    p1 = use_re_q ? ((ProdW+1)'(px1_q) + (ProdW+1)'(py1_q))
                  : ((ProdW+1)'(px1_q) - (ProdW+1)'(py1_q));
    p2 = use_re_q ? ((ProdW+1)'(px2_q) + (ProdW+1)'(py2_q))
                  : ((ProdW+1)'(px2_q) - (ProdW+1)'(py2_q));
    q  = sub_p2_q ? ((ProdW+2)'(p1) - (ProdW+2)'(p2))
                  : ((ProdW+2)'(p1) + (ProdW+2)'(p2));
    q2 = TermW'(q) <<< 1;
    term_d = neg_q ? -q2 : q2;
  end

  always_ff @(posedge clk_i) begin
    term_q <= term_d;
  end

  assign term_o = term_q;

endmodule

### src/acwa_store.sv
`timescale 1ns / 1ps

module acwa_store (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  acwa_pkg::store_rd_t          rd_i,
  input  acwa_pkg::store_wr_t          wr_i,
  output logic [acwa_pkg::SumW-1:0]    rd_data_o
);

  localparam int NumWalls = acwa_pkg::NumWalls;
  localparam int SumW     = acwa_pkg::SumW;

  logic [SumW-1:0]     mem_q [NumWalls];
  logic [NumWalls-1:0] valid_q;
  logic [SumW-1:0]     rd_data_q;
  logic                rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_i.en) begin
      rd_data_q <= mem_q[rd_i.addr];
    end
  end

  // untouched entries read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        valid_q[wr_i.addr] <= 1'b1;
      end
      if (rd_i.en) begin
        rd_valid_q <= valid_q[rd_i.addr];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule

### src/axial_current_wall_accumulator.sv
// Axial current wall accumulator.
// Command channel: present kind_i, wall_i and the spin fields with start;
// the beat is taken at a clock edge where start is high and busy is low.
// Kind 0 adds the direction's axial term to the wall, 1 reads it, 2 clears
// it, 3 reads. Each beat yields one result on wall_echo_o / wall_sum_o,
// marked by strobe_o for exactly one cycle; the receiver cannot stall.
// Order: the beat steps through the multiply, sum and update states;
// strobe_o is registered from the update state. Busy covers the memory
// read, the multiply stage, the term sum and the saturating write-back, so
// the next beat can be taken in the cycle that shows the previous result.
// Config: cfg_direction_i is written when cfg_valid_i is high (ready is
// always high); write it only while the block is idle.
// Reset: all walls read as zero, direction resets to t (3), no result
// pending; no clearing pass is needed.
`timescale 1ns / 1ps

module axial_current_wall_accumulator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [1:0]                  cfg_direction_i,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  kind_i,
  input  logic [5:0]                  wall_i,
  input  logic signed [15:0]          spin0_re_i,
  input  logic signed [15:0]          spin0_im_i,
  input  logic signed [15:0]          spin1_re_i,
  input  logic signed [15:0]          spin1_im_i,
  input  logic signed [15:0]          spin2_re_i,
  input  logic signed [15:0]          spin2_im_i,
  input  logic signed [15:0]          spin3_re_i,
  input  logic signed [15:0]          spin3_im_i,
  output logic                        strobe_o,
  output logic [5:0]                  wall_echo_o,
  output logic signed [47:0]          wall_sum_o
);

  localparam int AddrW    = acwa_pkg::AddrW;
  localparam int WallW    = acwa_pkg::WallW;
  localparam int SumW     = acwa_pkg::SumW;
  localparam int TermW    = acwa_pkg::TermW;
  localparam int NumWalls = acwa_pkg::NumWalls;

  acwa_pkg::state_e state_q, state_d;
  acwa_pkg::dir_e   dir_q;
  acwa_pkg::kind_e  kind_q;
  logic [WallW-1:0] wall_q;
  logic             in_range;
  logic             accept;

  acwa_pkg::cplx_t     s0, s1, s2, s3;
  logic signed [TermW-1:0] term;
  logic [SumW-1:0]     old_raw;
  logic signed [SumW-1:0] old_val;
  logic signed [SumW:0]   sum_w;
  logic signed [SumW-1:0] sat_val, new_val;

  acwa_pkg::store_rd_t rd;
  acwa_pkg::store_wr_t wr;

  logic                   strobe_q;
  logic [WallW-1:0]       echo_q;
  logic signed [SumW-1:0] res_q;

  assign cfg_ready_o = 1'b1;
  assign busy        = (state_q != acwa_pkg::StIdle);
  assign accept      = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= acwa_pkg::DirReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      dir_q <= acwa_pkg::dir_e'(cfg_direction_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= acwa_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      acwa_pkg::StIdle: if (accept) state_d = acwa_pkg::StMul;
      acwa_pkg::StMul:  state_d = acwa_pkg::StSum;
      acwa_pkg::StSum:  state_d = acwa_pkg::StUpd;
      acwa_pkg::StUpd:  state_d = acwa_pkg::StIdle;
      default:          state_d = acwa_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= acwa_pkg::kind_e'(kind_i);
      wall_q <= wall_i;
    end
  end

  assign in_range = (32'(wall_q) < NumWalls);

  assign s0 = '{re: spin0_re_i, im: spin0_im_i};
  assign s1 = '{re: spin1_re_i, im: spin1_im_i};
  assign s2 = '{re: spin2_re_i, im: spin2_im_i};
  assign s3 = '{re: spin3_re_i, im: spin3_im_i};

  acwa_term u_term (
    .clk_i  (clk_i),
    .load_i (accept),
    .dir_i  (dir_q),
    .s0_i   (s0),
    .s1_i   (s1),
    .s2_i   (s2),
    .s3_i   (s3),
    .term_o (term)
  );

  assign rd.en   = accept;
  assign rd.addr = AddrW'(wall_i);

  acwa_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_i      (rd),
    .wr_i      (wr),
    .rd_data_o (old_raw)
  );

  always_comb begin
    old_val = signed'(old_raw);
    sum_w   = (SumW+1)'(old_val) + (SumW+1)'(term);
    if (sum_w[SumW] != sum_w[SumW-1]) begin
      sat_val = sum_w[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
    end else begin
      sat_val = sum_w[SumW-1:0];
    end
    case (kind_q)
      acwa_pkg::KindAcc:   new_val = sat_val;
      acwa_pkg::KindClear: new_val = '0;
      default:             new_val = old_val;
    endcase
    if (!in_range) begin
      new_val = '0;
    end
  end

  assign wr.en   = (state_q == acwa_pkg::StUpd) && in_range &&
                   (kind_q == acwa_pkg::KindAcc || kind_q == acwa_pkg::KindClear);
  assign wr.addr = AddrW'(wall_q);
  assign wr.data = new_val;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= (state_q == acwa_pkg::StUpd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == acwa_pkg::StUpd) begin
      echo_q <= wall_q;
      res_q  <= new_val;
    end
  end

  assign strobe_o    = strobe_q;
  assign wall_echo_o = echo_q;
  assign wall_sum_o  = res_q;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##4 strobe_o)
    else $error("result not delivered four cycles after accept");

  a_idle_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> !busy)
    else $error("result shown while busy");

  a_from_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> $past(state_q) == acwa_pkg::StUpd)
    else $error("result without write-back step");

  a_clear_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == acwa_pkg::StUpd && kind_q == acwa_pkg::KindClear) |=> (wall_sum_o == '0))
    else $error("clear did not return zero");

endmodule

### tb/sv/tb_axial_current_wall_accumulator.sv
`timescale 1ns / 1ps

module tb_axial_current_wall_accumulator;
  import acwa_pkg::*;

  localparam int Hi = 32767;
  localparam int Lo = -32768;
  localparam int IdleLimit = 600;
  localparam int RandItems = 950;
  localparam int PhaseLen = 190;
  localparam logic signed [SumW-1:0] SumMax = {1'b0, {(SumW-1){1'b1}}};
  localparam logic signed [SumW-1:0] SumMin = {1'b1, {(SumW-1){1'b0}}};
  localparam logic signed [SumW-1:0] FullNegTerm = -48'sd8589934592;

  typedef struct packed {
    kind_e              kind;
    logic [WallW-1:0]   wall;
    cplx_t [3:0]        spin;
  } wall_cmd_t;

  typedef struct packed {
    logic [WallW-1:0]      wall;
    logic signed [SumW-1:0] sum;
  } wall_result_t;

  typedef struct packed {
    logic                   is_cfg;
    dir_e                   dir;
    wall_cmd_t              cmd;
    logic [15:0]            reps;
    logic                   typed;
    logic signed [SumW-1:0] want;
  } plan_row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [1:0] cfg_direction_i;
  logic start;
  logic busy;
  logic [1:0] kind_i;
  logic [5:0] wall_i;
  logic signed [15:0] spin0_re_i, spin0_im_i, spin1_re_i, spin1_im_i;
  logic signed [15:0] spin2_re_i, spin2_im_i, spin3_re_i, spin3_im_i;
  logic strobe_o;
  logic [5:0] wall_echo_o;
  logic signed [47:0] wall_sum_o;

  logic signed [SumW-1:0] wall_sum_mirror [NumWalls];
  dir_e direction_mirror;
  wall_result_t pending_results [$];
  int errors;
  int idle_cycles;

  axial_current_wall_accumulator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_direction_i(cfg_direction_i),
    .start          (start),
    .busy           (busy),
    .kind_i         (kind_i),
    .wall_i         (wall_i),
    .spin0_re_i     (spin0_re_i),
    .spin0_im_i     (spin0_im_i),
    .spin1_re_i     (spin1_re_i),
    .spin1_im_i     (spin1_im_i),
    .spin2_re_i     (spin2_re_i),
    .spin2_im_i     (spin2_im_i),
    .spin3_re_i     (spin3_re_i),
    .spin3_im_i     (spin3_im_i),
    .strobe_o       (strobe_o),
    .wall_echo_o    (wall_echo_o),
    .wall_sum_o     (wall_sum_o)
  );

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Re and Im of b * conj(a)
  function automatic logic signed [ProdW:0] pair_re(cplx_t a, cplx_t b);
    return (ProdW+1)'(b.re) * (ProdW+1)'(a.re) + (ProdW+1)'(b.im) * (ProdW+1)'(a.im);
  endfunction

  function automatic logic signed [ProdW:0] pair_im(cplx_t a, cplx_t b);
    return (ProdW+1)'(b.im) * (ProdW+1)'(a.re) - (ProdW+1)'(b.re) * (ProdW+1)'(a.im);
  endfunction

  function automatic logic signed [TermW-1:0] axial_term(dir_e d, cplx_t [3:0] s);
    logic signed [TermW-1:0] q;
    case (d)
      DirX: q = TermW'(pair_im(s[0], s[3])) + TermW'(pair_im(s[1], s[2]));
      DirY: q = TermW'(pair_re(s[0], s[3])) - TermW'(pair_re(s[1], s[2]));
      DirZ: q = TermW'(pair_im(s[0], s[2])) - TermW'(pair_im(s[1], s[3]));
      default: q = -(TermW'(pair_re(s[0], s[2])) + TermW'(pair_re(s[1], s[3])));
    endcase
    return q <<< 1;
  endfunction

  function automatic wall_result_t apply_wall_cmd(wall_cmd_t c);
    logic signed [SumW:0] nxt;
    wall_result_t r;
    case (c.kind)
      KindAcc: begin
        nxt = (SumW+1)'(wall_sum_mirror[c.wall]) +
              (SumW+1)'(axial_term(direction_mirror, c.spin));
        if (nxt > (SumW+1)'(SumMax)) begin
          nxt = (SumW+1)'(SumMax);
        end
        if (nxt < (SumW+1)'(SumMin)) begin
          nxt = (SumW+1)'(SumMin);
        end
        wall_sum_mirror[c.wall] = nxt[SumW-1:0];
      end
      KindClear: wall_sum_mirror[c.wall] = '0;
      default: ;
    endcase
    r.wall = c.wall;
    r.sum = wall_sum_mirror[c.wall];
    return r;
  endfunction

  function automatic cplx_t [3:0] sp(int r0, int i0, int r1, int i1,
                                     int r2, int i2, int r3, int i3);
    cplx_t [3:0] s;
    s[0].re = r0[CompW-1:0];
    s[0].im = i0[CompW-1:0];
    s[1].re = r1[CompW-1:0];
    s[1].im = i1[CompW-1:0];
    s[2].re = r2[CompW-1:0];
    s[2].im = i2[CompW-1:0];
    s[3].re = r3[CompW-1:0];
    s[3].im = i3[CompW-1:0];
    return s;
  endfunction

  function automatic plan_row_t cmd_row(kind_e k, logic [WallW-1:0] w, cplx_t [3:0] s,
                                        int reps, logic typed,
                                        logic signed [SumW-1:0] want);
    plan_row_t p;
    p.is_cfg = 1'b0;
    p.dir = DirReset;
    p.cmd.kind = k;
    p.cmd.wall = w;
    p.cmd.spin = s;
    p.reps = reps[15:0];
    p.typed = typed;
    p.want = want;
    return p;
  endfunction

  function automatic plan_row_t cfg_row(dir_e d);
    plan_row_t p;
    p = '0;
    p.is_cfg = 1'b1;
    p.dir = d;
    return p;
  endfunction

  function automatic logic [CompW-1:0] rand_comp();
    logic [CompW-1:0] v;
    case ($urandom_range(0, 9))
      0: v = 16'h8000;
      1: v = 16'h7fff;
      2: v = '0;
      3, 4: v = CompW'($urandom_range(0, 255) - 128);
      default: v = CompW'($urandom);
    endcase
    return v;
  endfunction

  function automatic wall_cmd_t random_cmd();
    wall_cmd_t c;
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      c.kind = KindAcc;
    end else if (r < 80) begin
      c.kind = KindRead;
    end else if (r < 90) begin
      c.kind = KindClear;
    end else begin
      c.kind = KindNone;
    end
    if ($urandom_range(0, 9) < 7) begin
      c.wall = WallW'($urandom_range(0, 7));
    end else begin
      c.wall = WallW'($urandom_range(0, NumWalls - 1));
    end
    for (int k = 0; k < 4; k++) begin
      c.spin[k].re = rand_comp();
      c.spin[k].im = rand_comp();
    end
    return c;
  endfunction

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 40);
  endfunction

  task automatic send_cmd(wall_cmd_t c, int gap, logic typed,
                          logic signed [SumW-1:0] want);
    wall_result_t r;
    if (gap > 0) begin
      @(negedge clk_i) start = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start = 1'b1;
    kind_i = c.kind;
    wall_i = c.wall;
    spin0_re_i = c.spin[0].re;
    spin0_im_i = c.spin[0].im;
    spin1_re_i = c.spin[1].re;
    spin1_im_i = c.spin[1].im;
    spin2_re_i = c.spin[2].re;
    spin2_im_i = c.spin[2].im;
    spin3_re_i = c.spin[3].re;
    spin3_im_i = c.spin[3].im;
    do @(posedge clk_i); while (busy !== 1'b0);
    r = apply_wall_cmd(c);
    if (typed) begin
      r.sum = want;
    end
    pending_results.push_back(r);
  endtask

  task automatic drain();
    @(negedge clk_i) start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_direction(dir_e d);
    drain();
    repeat (6) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_direction_i = d;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    direction_mirror = d;
    @(negedge clk_i) cfg_valid_i = 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && strobe_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: wall_echo %0d wall_sum %0d", wall_echo_o, wall_sum_o);
        errors++;
      end else begin
        wall_result_t e;
        e = pending_results.pop_front();
        if (wall_echo_o !== e.wall) begin
          $error("wall_echo: expected %0d, got %0d", e.wall, wall_echo_o);
          errors++;
        end
        if (wall_sum_o !== e.sum) begin
          $error("wall_sum: expected %0d, got %0d", e.sum, wall_sum_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && busy === 1'b0) || strobe_o === 1'b1 ||
        (cfg_valid_i && cfg_ready_o === 1'b1)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    plan_row_t plan [24];
    bit steady;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_direction_i = DirReset;
    start = 1'b0;
    kind_i = KindRead;
    wall_i = '0;
    spin0_re_i = '0;
    spin0_im_i = '0;
    spin1_re_i = '0;
    spin1_im_i = '0;
    spin2_re_i = '0;
    spin2_im_i = '0;
    spin3_re_i = '0;
    spin3_im_i = '0;
    errors = 0;
    idle_cycles = 0;
    direction_mirror = DirReset;
    for (int w = 0; w < NumWalls; w++) begin
      wall_sum_mirror[w] = '0;
    end

    plan = '{
      cmd_row(KindRead,  0,  sp(0, 0, 0, 0, 0, 0, 0, 0), 1, 1, '0),
      cmd_row(KindRead,  63, sp(Lo, Hi, Lo, Hi, Lo, Hi, Lo, Hi), 1, 1, '0),
      cmd_row(KindNone,  17, sp(Hi, Hi, Hi, Hi, Hi, Hi, Hi, Hi), 1, 1, '0),
      cmd_row(KindClear, 9,  sp(Lo, Lo, Lo, Lo, Lo, Lo, Lo, Lo), 1, 1, '0),
      cmd_row(KindAcc,   1,  sp(Lo, Lo, Lo, Lo, Lo, Lo, Lo, Lo), 1, 1, FullNegTerm),
      cmd_row(KindAcc,   1,  sp(Hi, Hi, Hi, Hi, Hi, Hi, Hi, Hi), 1, 0, '0),
      cmd_row(KindAcc,   2,  sp(Hi, Lo, Lo, Hi, Lo, Lo, Hi, Hi), 1, 0, '0),
      cfg_row(DirX),
      cmd_row(KindAcc,   3,  sp(Hi, Lo, Lo, Hi, Lo, Lo, Hi, Hi), 1, 0, '0),
      cmd_row(KindAcc,   3,  sp(Lo, Hi, Hi, Hi, Hi, Lo, Lo, Lo), 1, 0, '0),
      cfg_row(DirY),
      cmd_row(KindAcc,   4,  sp(Hi, Hi, Lo, Lo, Hi, Hi, Hi, Hi), 1, 0, '0),
      cmd_row(KindAcc,   4,  sp(Lo, Hi, Hi, Lo, Lo, Lo, Hi, Lo), 1, 0, '0),
      cfg_row(DirZ),
      cmd_row(KindAcc,   5,  sp(Hi, Lo, Lo, Hi, Lo, Lo, Hi, Hi), 1, 0, '0),
      cmd_row(KindAcc,   5,  sp(Hi, Hi, Lo, Hi, Lo, Hi, Hi, Lo), 1, 0, '0),
      cfg_row(DirT),
      // repeated full-scale hits on two walls, both signs
      cmd_row(KindAcc,   62, sp(Lo, Lo, Lo, Lo, Hi, Hi, Hi, Hi), 12, 0, '0),
      cmd_row(KindRead,  62, sp(0, 0, 0, 0, 0, 0, 0, 0), 1, 0, '0),
      cmd_row(KindAcc,   61, sp(Lo, Lo, Lo, Lo, Lo, Lo, Lo, Lo), 12, 0, '0),
      cmd_row(KindRead,  61, sp(0, 0, 0, 0, 0, 0, 0, 0), 1, 0, '0),
      cmd_row(KindAcc,   61, sp(Lo, Lo, Lo, Lo, Hi, Hi, Hi, Hi), 1, 0, '0),
      cmd_row(KindClear, 62, sp(Hi, Hi, Hi, Hi, Hi, Hi, Hi, Hi), 1, 1, '0),
      cmd_row(KindRead,  62, sp(0, 0, 0, 0, 0, 0, 0, 0), 1, 1, '0)
    };

    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        set_direction(plan[i].dir);
      end else begin
        repeat (plan[i].reps) begin
          send_cmd(plan[i].cmd, rand_gap(), plan[i].typed, plan[i].want);
        end
      end
    end

    steady = 1'b0;
    for (int n = 0; n < RandItems; n++) begin
      if (n % PhaseLen == 0) begin
        set_direction(dir_e'($urandom_range(0, 3)));
      end
      if (n % 64 == 0) begin
        steady = ($urandom_range(0, 3) == 0);
      end
      if (n == RandItems / 2 + 7) begin
        drain();
      end
      send_cmd(random_cmd(), steady ? 0 : rand_gap(), 1'b0, '0);
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
